/* rtl/core/bma_pkg.sv */
// Shared types, codes and defaults for the bus master arbiter.
package bma_pkg;

  localparam int NUM_MASTERS_DEF = 16;
  localparam int FIELD_W         = 16;
  localparam int MIDX_W          = 4;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // transfer types
  localparam logic [1:0] TRANS_IDLE   = 2'd0;
  localparam logic [1:0] TRANS_BUSY   = 2'd1;
  localparam logic [1:0] TRANS_NONSEQ = 2'd2;
  localparam logic [1:0] TRANS_SEQ    = 2'd3;

  // burst types
  localparam logic [2:0] BURST_SINGLE = 3'd0;
  localparam logic [2:0] BURST_INCR   = 3'd1;
  localparam logic [2:0] BURST_WRAP4  = 3'd2;
  localparam logic [2:0] BURST_INCR4  = 3'd3;
  localparam logic [2:0] BURST_WRAP8  = 3'd4;
  localparam logic [2:0] BURST_INCR8  = 3'd5;
  localparam logic [2:0] BURST_WRAP16 = 3'd6;
  localparam logic [2:0] BURST_INCR16 = 3'd7;

  // beat marks of the fixed-length bursts: last beats, and the first beat
  localparam logic [3:0] BEAT_LAST4  = 4'h3;
  localparam logic [3:0] BEAT_LAST8  = 4'h7;
  localparam logic [3:0] BEAT_LAST16 = 4'hf;
  localparam logic [3:0] BEAT_FIRST  = 4'h1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RR_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_BURST = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIO_MASK   = 3'd4;

  typedef struct packed {
    logic [FIELD_W-1:0] bus_requests;
    logic [FIELD_W-1:0] lock_requests;
    logic [FIELD_W-1:0] active_transfers;
    logic [FIELD_W-1:0] split_pending;
    logic [1:0]         current_trans_type;
    logic [2:0]         current_burst_type;
    logic               bus_ready;
  } item_t;

  typedef struct packed {
    logic [MIDX_W-1:0] granted_master;
    logic              grant_valid;
    logic              rearbitrated;
  } result_t;

  // settings that the selector needs
  typedef struct packed {
    logic               round_robin_mode;
    logic               split_enable;
    logic [MIDX_W-1:0]  default_master;
    logic [FIELD_W-1:0] priority_masters;
  } sel_cfg_t;

endpackage

/* rtl/core/bma_select.sv */
// Master selection: round robin with priority mask, or fixed highest-index priority.
module bma_select #(
  parameter int NUM_MASTERS = bma_pkg::NUM_MASTERS_DEF
) (
  input  bma_pkg::sel_cfg_t           cfg,
  input  logic [bma_pkg::FIELD_W-1:0] req,
  input  logic [bma_pkg::FIELD_W-1:0] spl,
  input  logic [bma_pkg::MIDX_W-1:0]  cur,
  output logic [bma_pkg::MIDX_W-1:0]  mast,
  output logic                        dmy
);
  import bma_pkg::*;

  localparam logic [FIELD_W-1:0] MMASK = FIELD_W'((32'd1 << NUM_MASTERS) - 32'd1);
  localparam logic [MIDX_W:0]    NUM_W = (MIDX_W+1)'(NUM_MASTERS);
  localparam logic [MIDX_W-1:0]  LAST  = MIDX_W'(NUM_MASTERS - 1);

  logic [FIELD_W-1:0] elig;
  logic [FIELD_W-1:0] prio;
  logic               any_valid;
  logic               hi_valid;
  logic               up_found;
  logic [MIDX_W-1:0]  hi_idx;
  logic [MIDX_W-1:0]  top_idx;
  logic [MIDX_W-1:0]  up_idx;
  logic [MIDX_W-1:0]  low_idx;
  logic [MIDX_W-1:0]  dflt;
  logic [MIDX_W-1:0]  nxt;

  always_comb begin
    elig = req & MMASK;
    if (cfg.split_enable) begin
      elig = elig & ~spl;
    end
    prio      = elig & cfg.priority_masters;
    any_valid = |elig;

    top_idx  = '0;
    hi_idx   = '0;
    hi_valid = 1'b0;
    for (int i = 0; i < FIELD_W; i++) begin
      if (elig[i]) begin
        top_idx = MIDX_W'(i);
      end
      if (prio[i]) begin
        hi_idx   = MIDX_W'(i);
        hi_valid = 1'b1;
      end
    end

    // lowest requester above the current master, and lowest overall
    up_idx   = '0;
    up_found = 1'b0;
    low_idx  = '0;
    for (int i = FIELD_W - 1; i >= 0; i--) begin
      if (elig[i] && (MIDX_W'(i) > cur)) begin
        up_idx   = MIDX_W'(i);
        up_found = 1'b1;
      end
      if (elig[i]) begin
        low_idx = MIDX_W'(i);
      end
    end

    if (cfg.round_robin_mode) begin
      nxt  = up_found ? up_idx : low_idx;
      dflt = cur;
    end else begin
      hi_valid = 1'b0;
      nxt      = top_idx;
      dflt     = ({1'b0, cfg.default_master} < NUM_W) ? cfg.default_master : LAST;
    end

    if (hi_valid) begin
      mast = hi_idx;
    end else if (any_valid) begin
      mast = nxt;
    end else begin
      mast = dflt;
    end

    dmy = !any_valid && cfg.split_enable && ((spl & MMASK) != '0);
  end

endmodule

/* rtl/core/bus_master_arbiter.sv */
// Top level of the bus master arbiter: handshakes, configuration and arbitration state.
//
// Usage: each transfer on the item channel describes one bus cycle (all masters'
// request, lock, active and split bits, the current master's transfer and burst
// type, and the bus ready flag). The block answers each item with exactly one
// result transfer: the granted master, whether a real master holds the bus, and
// whether arbitration was performed in that cycle.
// Path: an accepted item is held in the input register, then evaluated and latched
// in the result register, from which its result is offered to the receiver.
// Throughput: one item per cycle while result_ready is high; the arbitration state
// (current master, lock, beat counter, dummy flag) is updated in the same cycle the
// item moves to the result register, so consecutive items chain without a gap.
// Stall: when the receiver holds result_ready low, the result register holds,
// the input register fills once more and then item_ready drops.
// Configuration: cfg_ready is always high; write only while no item is in flight.
// Reset (rst, synchronous): round robin on, split and fixed burst off, default
// master 0, no priority masters; current master 0, unlocked, beat 1, no dummy.
module bus_master_arbiter #(
  parameter int NUM_MASTERS = bma_pkg::NUM_MASTERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  bma_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_ready,
  output bma_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bma_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bma_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bma_pkg::*;

  localparam logic [FIELD_W-1:0] MMASK = FIELD_W'((32'd1 << NUM_MASTERS) - 32'd1);

  // configuration registers
  logic               round_robin_mode;
  logic               split_enable;
  logic               fixed_burst_enable;
  logic [MIDX_W-1:0]  default_master;
  logic [FIELD_W-1:0] priority_masters;

  // arbitration state
  logic [MIDX_W-1:0]  current_master;
  logic               master_locked;
  logic [3:0]         burst_beat;
  logic               dummy_selected;

  // input register
  logic               held_valid;
  item_t              held;

  logic               advance;
  logic [FIELD_W-1:0] req;
  logic [FIELD_W-1:0] lck;
  logic [FIELD_W-1:0] act;
  logic [FIELD_W-1:0] spl;
  logic               cur_req;
  logic               arb;
  logic [MIDX_W-1:0]  sel_mast;
  logic               sel_dmy;
  logic [MIDX_W-1:0]  nmast;
  logic               dmy;
  logic [MIDX_W-1:0]  owner;
  logic [MIDX_W-1:0]  current_master_next;
  logic               master_locked_next;
  logic [3:0]         burst_beat_next;
  logic               dummy_selected_next;
  sel_cfg_t           sel_cfg;

  assign cfg_ready  = 1'b1;
  // advance the held item whenever the result register is free or being drained
  assign advance    = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      round_robin_mode   <= 1'b1;
      split_enable       <= 1'b0;
      fixed_burst_enable <= 1'b0;
      default_master     <= '0;
      priority_masters   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RR_MODE:     round_robin_mode   <= cfg_data[0];
        REG_SPLIT_EN:    split_enable       <= cfg_data[0];
        REG_FIXED_BURST: fixed_burst_enable <= cfg_data[0];
        REG_DEFAULT_MST: default_master     <= cfg_data[MIDX_W-1:0];
        REG_PRIO_MASK:   priority_masters   <= cfg_data[FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: take a new transfer whenever it is empty or the held one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

  // drop bits of masters that do not exist
  assign req     = held.bus_requests & MMASK;
  assign lck     = held.lock_requests & MMASK;
  assign act     = held.active_transfers & MMASK;
  assign spl     = held.split_pending & MMASK;
  assign cur_req = req[current_master];

  // rearbitration decision
  always_comb begin
    arb = 1'b0;
    if (!master_locked) begin
      case (held.current_trans_type)
        TRANS_IDLE: arb = 1'b1;
        TRANS_NONSEQ: begin
          if (held.current_burst_type == BURST_SINGLE) begin
            arb = 1'b1;
          end else if (held.current_burst_type == BURST_INCR) begin
            arb = !cur_req;
          end
        end
        TRANS_SEQ: begin
          if (held.current_burst_type == BURST_INCR) begin
            arb = !cur_req;
          end else if (fixed_burst_enable) begin
            case (held.current_burst_type)
              BURST_WRAP4, BURST_INCR4:
                arb = ((burst_beat & BEAT_LAST4) == BEAT_LAST4);
              BURST_WRAP8, BURST_INCR8:
                arb = ((burst_beat & BEAT_LAST8) == BEAT_LAST8);
              BURST_WRAP16, BURST_INCR16:
                arb = ((burst_beat & BEAT_LAST16) == BEAT_LAST16);
              default: arb = 1'b0;
            endcase
          end
        end
        default: arb = 1'b0;
      endcase
    end
    // a dummy-held bus is released as soon as an unsplit master wants it
    if (split_enable && dummy_selected && (((act | req) & ~spl) != '0)) begin
      arb = 1'b1;
    end
  end

  assign sel_cfg = '{round_robin_mode: round_robin_mode,
                     split_enable:     split_enable,
                     default_master:   default_master,
                     priority_masters: priority_masters};

  bma_select #(
    .NUM_MASTERS(NUM_MASTERS)
  ) u_select (
    .cfg  (sel_cfg),
    .req  (req),
    .spl  (spl),
    .cur  (current_master),
    .mast (sel_mast),
    .dmy  (sel_dmy)
  );

  assign nmast = arb ? sel_mast : current_master;
  assign dmy   = arb ? sel_dmy : (split_enable && dummy_selected);
  assign owner = held.bus_ready ? nmast : current_master;

  // next arbitration state
  always_comb begin
    current_master_next = current_master;
    burst_beat_next     = burst_beat;
    dummy_selected_next = dummy_selected;
    if (held.bus_ready) begin
      if (held.current_trans_type == TRANS_IDLE ||
          held.current_trans_type == TRANS_NONSEQ) begin
        burst_beat_next = BEAT_FIRST;
      end else if (held.current_trans_type == TRANS_SEQ && fixed_burst_enable) begin
        burst_beat_next = burst_beat + 4'd1;
      end
      current_master_next = nmast;
      dummy_selected_next = split_enable && dmy;
    end else if (!split_enable) begin
      dummy_selected_next = 1'b0;
    end
    master_locked_next = lck[owner] || (master_locked && !held.bus_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_master <= '0;
      master_locked  <= 1'b0;
      burst_beat     <= BEAT_FIRST;
      dummy_selected <= 1'b0;
    end else if (advance) begin
      current_master <= current_master_next;
      master_locked  <= master_locked_next;
      burst_beat     <= burst_beat_next;
      dummy_selected <= dummy_selected_next;
    end
  end

  // result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= advance || (result_valid && !result_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.granted_master <= nmast;
      result.grant_valid    <= !dmy;
      result.rearbitrated   <= arb;
    end
  end

endmodule

/* bench/bus_master_arbiter_tb.sv */
// Self-checking testbench for the bus master arbiter: directed cycles, then random bursts, split storms and noise.
module bus_master_arbiter_tb;
  import bma_pkg::*;

  // Clock, reset and the three channels of the block
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cyc_valid = 1'b0;
  logic                  cyc_ready;
  item_t                 cyc = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  result_t               res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bus_master_arbiter dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (cyc_valid),
    .item_ready   (cyc_ready),
    .item         (cyc),
    .result_valid (res_valid),
    .result_ready (res_ready),
    .result       (res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the arbiter's settings, updated when a register write is accepted
  logic        rr_mode        = 1'b1;
  logic        split_en       = 1'b0;
  logic        fixed_burst_en = 1'b0;
  logic [3:0]  dflt_master    = 4'd0;
  logic [15:0] prio_mask      = 16'h0000;

  // Shadow copy of the arbitration state, advanced on every accepted bus cycle
  logic [3:0]  cur_master  = 4'd0;
  logic        is_locked   = 1'b0;
  logic [3:0]  beat_count  = BEAT_FIRST;
  logic        dummy_held  = 1'b0;

  item_t       bus_cycles_pending[$];
  result_t     grants_expected[$];
  result_t     grant_want;

  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 54;
  int unsigned fail_count    = 0;
  int unsigned grants_checked = 0;
  int unsigned rearb_seen    = 0;
  int unsigned dummy_seen    = 0;
  int unsigned settings_used = 1;

  // Work out the grant for one bus cycle and advance the shadow state, as the block
  // would when the cycle reaches it.
  function automatic result_t predict_grant(item_t c);
    logic [15:0] elig;
    logic        arb;
    logic        dmy;
    logic        hi_valid;
    logic        found;
    logic [3:0]  nmast;
    logic [3:0]  hi;
    logic [3:0]  nxt;
    logic [3:0]  held;
    result_t     r;
    arb   = 1'b0;
    dmy   = 1'b0;
    nmast = cur_master;
    // A locked master keeps the bus whatever it does
    if (!is_locked) begin
      case (c.current_trans_type)
        TRANS_IDLE: arb = 1'b1;
        TRANS_NONSEQ: begin
          if (c.current_burst_type == BURST_SINGLE) arb = 1'b1;
          else if (c.current_burst_type == BURST_INCR)
            arb = !c.bus_requests[cur_master];
        end
        TRANS_SEQ: begin
          if (c.current_burst_type == BURST_INCR) begin
            arb = !c.bus_requests[cur_master];
          end else if (fixed_burst_en) begin
            // rearbitrate only on the last beat of a fixed-length burst
            case (c.current_burst_type)
              BURST_WRAP4, BURST_INCR4:   arb = (beat_count & BEAT_LAST4) == BEAT_LAST4;
              BURST_WRAP8, BURST_INCR8:   arb = (beat_count & BEAT_LAST8) == BEAT_LAST8;
              BURST_WRAP16, BURST_INCR16: arb = (beat_count & BEAT_LAST16) == BEAT_LAST16;
              default: ;
            endcase
          end
        end
        default: ; // busy: hold the bus and the beat count
      endcase
    end
    // The dummy master gives way as soon as a master that is not split shows up
    if (split_en && dummy_held &&
        ((c.active_transfers | c.bus_requests) & ~c.split_pending) != 16'h0)
      arb = 1'b1;

    if (arb) begin
      elig = c.bus_requests;
      if (split_en) elig &= ~c.split_pending;
      hi_valid = 1'b0;
      found    = 1'b0;
      hi       = 4'd0;
      nxt      = 4'd0;
      if (rr_mode) begin
        // first requester above the current master, else wrap to the lowest
        for (int i = 0; i < 16; i++)
          if (!found && i > cur_master && elig[i]) begin
            nxt   = 4'(i);
            found = 1'b1;
          end
        for (int i = 0; i < 16; i++)
          if (!found && elig[i]) begin
            nxt   = 4'(i);
            found = 1'b1;
          end
        // the highest preferred requester overrides the rotation
        for (int i = 0; i < 16; i++)
          if (elig[i] && prio_mask[i]) begin
            hi       = 4'(i);
            hi_valid = 1'b1;
          end
      end else begin
        for (int i = 0; i < 16; i++)
          if (elig[i]) nxt = 4'(i);
      end
      // with sixteen masters the default master can never lie out of range
      if (hi_valid) nmast = hi;
      else if (elig != 16'h0) nmast = nxt;
      else nmast = rr_mode ? cur_master : dflt_master;
      dmy = split_en && !hi_valid && elig == 16'h0 && c.split_pending != 16'h0;
    end else if (split_en) begin
      dmy = dummy_held;
    end

    r.granted_master = nmast;
    r.grant_valid    = !dmy;
    r.rearbitrated   = arb;

    held = c.bus_ready ? nmast : cur_master;
    if (c.bus_ready) begin
      if (c.current_trans_type == TRANS_IDLE || c.current_trans_type == TRANS_NONSEQ)
        beat_count = BEAT_FIRST;
      else if (c.current_trans_type == TRANS_SEQ && fixed_burst_en)
        beat_count = beat_count + 4'd1;
      cur_master = nmast;
      dummy_held = split_en & dmy;
    end else if (!split_en) begin
      dummy_held = 1'b0;
    end
    is_locked = c.lock_requests[held] | (is_locked & !c.bus_ready);
    return r;
  endfunction

  function automatic item_t make_cycle(logic [15:0] req, logic [15:0] lck, logic [15:0] act,
                                       logic [15:0] spl, logic [1:0] trans,
                                       logic [2:0] burst, logic ready);
    item_t c;
    c.bus_requests       = req;
    c.lock_requests      = lck;
    c.active_transfers   = act;
    c.split_pending      = spl;
    c.current_trans_type = trans;
    c.current_burst_type = burst;
    c.bus_ready          = ready;
    return c;
  endfunction

  // Masks of every density: empty, one master, sparse, half, everybody
  function automatic logic [15:0] pick_mask();
    case ($urandom_range(4))
      0:       return 16'h0000;
      1:       return 16'h0001 << $urandom_range(15);
      2:       return 16'($urandom);
      3:       return 16'($urandom & $urandom);
      default: return 16'hffff;
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
    fail_count++;
    if (fail_count <= 40)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // Write one register; leave valid high so that a following write runs back to back
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RR_MODE:     rr_mode        = val[0];
      REG_SPLIT_EN:    split_en       = val[0];
      REG_FIXED_BURST: fixed_burst_en = val[0];
      REG_DEFAULT_MST: dflt_master    = val[3:0];
      REG_PRIO_MASK:   prio_mask      = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic rr, logic sp, logic fx, logic [3:0] dm, logic [15:0] pm);
    @(posedge clk);
    write_reg(REG_RR_MODE,     16'(rr));
    write_reg(REG_SPLIT_EN,    16'(sp));
    write_reg(REG_FIXED_BURST, 16'(fx));
    write_reg(REG_DEFAULT_MST, 16'(dm));
    write_reg(REG_PRIO_MASK,   pm);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Wait until every queued cycle has been sent and every grant has come back
  task automatic drain();
    do @(negedge clk);
    while (bus_cycles_pending.size() != 0 || cyc_valid || grants_expected.size() != 0);
  endtask

  // Driver: predict each accepted transfer, then offer the next cycle or idle
  always @(posedge clk) begin
    if (rst) begin
      cyc_valid <= 1'b0;
    end else begin
      if (cyc_valid && cyc_ready)
        grants_expected.push_back(predict_grant(cyc));
      if (!cyc_valid || cyc_ready) begin
        if (bus_cycles_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cyc       <= bus_cycles_pending.pop_front();
          cyc_valid <= 1'b1;
        end else begin
          cyc_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (grants_expected.size() == 0) begin
          flag_mismatch("unexpected result", 16'h0, 16'(res));
        end else begin
          grant_want = grants_expected.pop_front();
          grants_checked++;
          if (grant_want.rearbitrated) rearb_seen++;
          if (!grant_want.grant_valid) dummy_seen++;
          if (res.granted_master !== grant_want.granted_master)
            flag_mismatch("granted_master", 16'(grant_want.granted_master),
                          16'(res.granted_master));
          if (res.grant_valid !== grant_want.grant_valid)
            flag_mismatch("grant_valid", 16'(grant_want.grant_valid), 16'(res.grant_valid));
          if (res.rearbitrated !== grant_want.rearbitrated)
            flag_mismatch("rearbitrated", 16'(grant_want.rearbitrated),
                          16'(res.rearbitrated));
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus: directed cycles under two settings, then six random phases
  initial begin
    logic [2:0]  kind;
    logic [15:0] reqs;
    logic [15:0] spl;
    logic [15:0] lck;
    logic        rdy;
    logic        rr;
    logic        sp;
    logic        fx;
    logic [3:0]  dm;
    logic [15:0] pm;
    int          beats;
    int          roll;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: round robin, no split, no fixed-burst rearbitration
    bus_cycles_pending.push_back(make_cycle(16'h0000, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_IDLE, BURST_SINGLE, 1'b1)); // nobody asks
    bus_cycles_pending.push_back(make_cycle(16'hffff, 16'h0, 16'hffff, 16'h0000,
                                            TRANS_IDLE, BURST_SINGLE, 1'b1)); // next above 0
    bus_cycles_pending.push_back(make_cycle(16'h0001, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_NONSEQ, BURST_SINGLE, 1'b1)); // wrap to 0
    bus_cycles_pending.push_back(make_cycle(16'h0001, 16'h0, 16'h0001, 16'h0000,
                                            TRANS_NONSEQ, BURST_INCR, 1'b1)); // still asking
    bus_cycles_pending.push_back(make_cycle(16'h8000, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_SEQ, BURST_INCR, 1'b1)); // request dropped
    bus_cycles_pending.push_back(make_cycle(16'hffff, 16'h0, 16'hffff, 16'hffff,
                                            TRANS_BUSY, BURST_INCR16, 1'b1)); // busy holds
    bus_cycles_pending.push_back(make_cycle(16'h0001, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_NONSEQ, BURST_SINGLE, 1'b0)); // not latched
    bus_cycles_pending.push_back(make_cycle(16'h0001, 16'hffff, 16'h0000, 16'h0000,
                                            TRANS_IDLE, BURST_WRAP4, 1'b1)); // take the lock
    bus_cycles_pending.push_back(make_cycle(16'hffff, 16'h0, 16'hffff, 16'h0000,
                                            TRANS_IDLE, BURST_SINGLE, 1'b1)); // locked
    bus_cycles_pending.push_back(make_cycle(16'hffff, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_SEQ, BURST_WRAP8, 1'b1));
    bus_cycles_pending.push_back(make_cycle(16'h0000, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_SEQ, BURST_INCR8, 1'b1));
    bus_cycles_pending.push_back(make_cycle(16'h0000, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_SEQ, BURST_WRAP16, 1'b1));
    drain();

    // Split and fixed bursts on, masters 4 to 7 preferred
    apply_settings(1'b1, 1'b1, 1'b1, 4'd15, 16'h00f0);
    @(negedge clk);
    bus_cycles_pending.push_back(make_cycle(16'h0f3f, 16'h0, 16'h0000, 16'h0000,
                                            TRANS_IDLE, BURST_SINGLE, 1'b1)); // preferred wins
    bus_cycles_pending.push_back(make_cycle(16'h0006, 16'h0, 16'h0006, 16'h0000,
                                            TRANS_NONSEQ, BURST_WRAP4, 1'b1));
    bus_cycles_pending.push_back(make_cycle(16'h0006, 16'h0, 16'h0006, 16'h0000,
                                            TRANS_SEQ, BURST_WRAP4, 1'b1));
    bus_cycles_pending.push_back(make_cycle(16'h0006, 16'h0, 16'h0006, 16'h0000,
                                            TRANS_SEQ, BURST_INCR4, 1'b1));
    bus_cycles_pending.push_back(make_cycle(16'h0006, 16'h0, 16'h0006, 16'h0000,
                                            TRANS_SEQ, BURST_INCR4, 1'b1)); // last beat
    bus_cycles_pending.push_back(make_cycle(16'hffff, 16'h0, 16'h0000, 16'hffff,
                                            TRANS_IDLE, BURST_SINGLE, 1'b1)); // all split
    bus_cycles_pending.push_back(make_cycle(16'hffff, 16'h0, 16'hffff, 16'hffff,
                                            TRANS_NONSEQ, BURST_INCR, 1'b1)); // dummy stays
    bus_cycles_pending.push_back(make_cycle(16'h0000, 16'h0, 16'h0400, 16'hf000,
                                            TRANS_BUSY, BURST_SINGLE, 1'b1)); // active only
    bus_cycles_pending.push_back(make_cycle(16'h0400, 16'h0, 16'h0000, 16'hf000,
                                            TRANS_BUSY, BURST_SINGLE, 1'b1)); // dummy leaves
    bus_cycles_pending.push_back(make_cycle(16'h0000, 16'h0, 16'h0000, 16'hffff,
                                            TRANS_IDLE, BURST_SINGLE, 1'b0));
    drain();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin rr = 1'b1; sp = 1'b1; fx = 1'b1; dm = 4'd0;  pm = 16'h0000; end
        1: begin rr = 1'b0; sp = 1'b0; fx = 1'b1; dm = 4'd15; pm = 16'h0000; end
        2: begin rr = 1'b1; sp = 1'b0; fx = 1'b1; dm = 4'd7;  pm = 16'hffff; end
        3: begin rr = 1'b0; sp = 1'b1; fx = 1'b0; dm = 4'd0;  pm = 16'hffff; end
        4: begin rr = 1'b1; sp = 1'b1; fx = 1'b0; dm = 4'd15; pm = 16'h8001; end
        default: begin
          rr = 1'($urandom);
          sp = 1'($urandom);
          fx = 1'($urandom);
          dm = 4'($urandom);
          pm = 16'($urandom);
        end
      endcase
      apply_settings(rr, sp, fx, dm, pm);
      @(negedge clk);
      // swap the idling sides after two phases, then run flat out for the last two
      send_idle_pct = (p < 2) ? 19 : (p < 4) ? 54 : 0;
      recv_idle_pct = (p < 2) ? 54 : (p < 4) ? 19 : 0;

      while (bus_cycles_pending.size() < 175) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          // Well-formed burst: nonseq then seq beats, wait states repeat a beat
          kind = 3'($urandom_range(7));
          case (kind)
            BURST_SINGLE:             beats = 1;
            BURST_INCR:               beats = $urandom_range(1, 6);
            BURST_WRAP4, BURST_INCR4: beats = 4;
            BURST_WRAP8, BURST_INCR8: beats = 8;
            default:                  beats = 16;
          endcase
          reqs = pick_mask();
          for (int b = 0; b < beats; b++) begin
            spl = ($urandom_range(3) == 0) ? pick_mask() : 16'h0000;
            lck = ($urandom_range(5) == 0) ? pick_mask() : 16'h0000;
            if (b != 0 && $urandom_range(9) == 0)
              bus_cycles_pending.push_back(make_cycle(reqs, lck, pick_mask(), spl,
                                                      TRANS_BUSY, kind, 1'b1));
            // on some incrementing bursts, drop the request on the last beat
            if (kind == BURST_INCR && b == beats - 1 && $urandom_range(1) == 1)
              reqs = 16'h0000;
            do begin
              rdy = ($urandom_range(99) < 85);
              bus_cycles_pending.push_back(make_cycle(reqs, lck, pick_mask(), spl,
                                                      (b == 0) ? TRANS_NONSEQ : TRANS_SEQ,
                                                      kind, rdy));
            end while (!rdy);
          end
          if ($urandom_range(2) == 0)
            bus_cycles_pending.push_back(make_cycle(pick_mask(), 16'h0000, 16'h0000,
                                                    16'h0000, TRANS_IDLE, BURST_SINGLE, 1'b1));
        end else if (roll < 85) begin
          // Split storm: only split masters ask, then any master may ask again
          spl = pick_mask() | (16'h0001 << $urandom_range(15));
          repeat ($urandom_range(2, 6))
            bus_cycles_pending.push_back(make_cycle(16'($urandom) & spl, 16'h0000,
                                                    16'($urandom) & spl, spl,
                                                    $urandom_range(1) ? TRANS_IDLE
                                                                      : 2'($urandom),
                                                    3'($urandom),
                                                    $urandom_range(3) != 0));
          bus_cycles_pending.push_back(make_cycle(pick_mask(), 16'h0000, pick_mask(), spl,
                                                  TRANS_IDLE, BURST_SINGLE, 1'b1));
        end else begin
          // Noise: every field free
          bus_cycles_pending.push_back(make_cycle(16'($urandom), 16'($urandom),
                                                  16'($urandom), 16'($urandom),
                                                  2'($urandom), 3'($urandom), 1'($urandom)));
        end
      end
      drain();
    end

    // let any stray result show up before the verdict
    repeat (6) @(posedge clk);
    $display("checked %0d grants under %0d settings of the arbiter", grants_checked,
             settings_used);
    $display("%0d cycles rearbitrated, %0d held by the idle dummy master", rearb_seen,
             dummy_seen);
    if (fail_count == 0) begin
      $display("bus_master_arbiter_tb passed");
    end else begin
      $display("bus_master_arbiter_tb failed");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #5000000;
    $display("bus_master_arbiter_tb failed");
    $finish;
  end

endmodule
